@@ hdl/sts_pkg.sv @@
package sts_pkg;

	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CHAN_W = 3;
	localparam int unsigned PEAK_W = 15;
	localparam int unsigned ENTRY_W = 31;
	localparam int unsigned Q30_SHIFT = 30;

	localparam logic [PEAK_W-1:0] PEAK_8BIT = 15'd127;
	localparam logic [PEAK_W-1:0] PEAK_16BIT = 15'd32767;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic [31:0] RST_PHASE_STEP = 32'd42852281;
	localparam logic RST_SAMPLE_WIDTH = 1'b1;
	localparam logic [3:0] RST_CHANNEL_COUNT = 4'd2;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint signed Q30_ONE = 64'd1073741824;
	localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [CHAN_W-1:0] cnt_m1;
		logic buf_end;
	} frame_t;

	// sin(pi/2 * k / 2^qbits) in unsigned q30, integer taylor series
	function automatic logic [ENTRY_W-1:0] quarter_sine(input int unsigned k,
		input int unsigned qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint signed sum;
		x = (HALF_PI_Q30 * longint'(k)) >> qbits;
		x2 = (x * x) >> Q30_SHIFT;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> Q30_SHIFT) / TAYLOR_DIV[n];
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > Q30_ONE) begin
			sum = Q30_ONE;
		end
		return ENTRY_W'(sum);
	endfunction

endpackage

@@ hdl/sts_ifs.sv @@
interface sts_req_if;
	logic valid;
	logic ready;
	logic restart;
	logic end_of_buffer;
	modport source (output valid, output restart, output end_of_buffer, input ready);
	modport sink (input valid, input restart, input end_of_buffer, output ready);
endinterface

interface sts_smp_if;
	logic valid;
	logic ready;
	logic signed [15:0] sample;
	logic [2:0] channel;
	logic last;
	logic buffer_end;
	modport source (output valid, output sample, output channel, output last,
		output buffer_end, input ready);
	modport sink (input valid, input sample, input channel, input last,
		input buffer_end, output ready);
endinterface

interface sts_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/sts_front.sv @@
module sts_front #(
	parameter int PHASE_BITS = 32,
	parameter int QUARTER_TABLE_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	sts_req_if.sink req,
	input logic [31:0] phase_step,
	input logic sample_width,
	input logic [sts_pkg::CHAN_W-1:0] cnt_m1,
	input logic pop,
	output logic push,
	output sts_pkg::frame_t push_data
);

	localparam int QS = 2 ** QUARTER_TABLE_BITS;
	localparam int AW = QUARTER_TABLE_BITS + 1;
	localparam int PW = sts_pkg::ENTRY_W + sts_pkg::PEAK_W;

	logic [sts_pkg::ENTRY_W-1:0] tab [QS+1];

	for (genvar g = 0; g <= QS; g++) begin : g_tab
		assign tab[g] = sts_pkg::quarter_sine(g, QUARTER_TABLE_BITS);
	end

	logic [sts_pkg::QCNT_W-1:0] credit_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_now;
	logic [QUARTER_TABLE_BITS-1:0] idx;
	logic accept;

	logic v_s1, v_s2, v_s3;
	logic neg_s1, neg_s2, neg_s3;
	logic be_s1, be_s2, be_s3;
	logic [AW-1:0] addr_s1;
	logic [sts_pkg::ENTRY_W-1:0] entry_s2;
	logic [PW-1:0] prod_s3;
	logic [PW:0] rounded;
	logic [sts_pkg::PEAK_W-1:0] mag;
	logic [sts_pkg::PEAK_W-1:0] peak;

	assign req.ready = credit_q < sts_pkg::QCNT_W'(sts_pkg::QDEPTH);
	assign accept = req.valid && req.ready;
	assign phase_now = req.restart ? '0 : phase_q;
	assign idx = phase_now[PHASE_BITS-3 -: QUARTER_TABLE_BITS];
	assign peak = sample_width ? sts_pkg::PEAK_16BIT : sts_pkg::PEAK_8BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			phase_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			credit_q <= credit_q + sts_pkg::QCNT_W'(accept) - sts_pkg::QCNT_W'(pop);
			if (accept) begin
				phase_q <= phase_now + PHASE_BITS'(phase_step);
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= phase_now[PHASE_BITS-1];
		be_s1 <= req.end_of_buffer;
		addr_s1 <= phase_now[PHASE_BITS-2] ? (AW'(QS) - AW'(idx)) : AW'(idx);
		entry_s2 <= tab[addr_s1];
		neg_s2 <= neg_s1;
		be_s2 <= be_s1;
		prod_s3 <= PW'(entry_s2) * PW'(peak);
		neg_s3 <= neg_s2;
		be_s3 <= be_s2;
	end

	assign rounded = {1'b0, prod_s3} + (PW+1)'(64'd1 << (sts_pkg::Q30_SHIFT - 1));
	assign mag = (rounded[PW:sts_pkg::Q30_SHIFT] > (PW+1-sts_pkg::Q30_SHIFT)'(peak)) ?
		peak : rounded[sts_pkg::Q30_SHIFT +: sts_pkg::PEAK_W];

	assign push = v_s3;
	assign push_data.sample = neg_s3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	assign push_data.cnt_m1 = cnt_m1;
	assign push_data.buf_end = be_s3;

endmodule

@@ hdl/sts_queue.sv @@
module sts_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sts_pkg::frame_t wdata,
	input logic pop,
	output logic empty,
	output sts_pkg::frame_t rdata
);

	sts_pkg::frame_t mem_q [sts_pkg::QDEPTH];
	logic [sts_pkg::QPTR_W-1:0] wr_q;
	logic [sts_pkg::QPTR_W-1:0] rd_q;
	logic [sts_pkg::QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + sts_pkg::QCNT_W'(push) - sts_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

endmodule

@@ hdl/sts_back.sv @@
module sts_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input sts_pkg::frame_t head,
	output logic pop,
	sts_smp_if.source smp
);

	logic [sts_pkg::CHAN_W-1:0] chan_q;
	logic valid_q;
	logic signed [sts_pkg::SAMPLE_W-1:0] sample_q;
	logic [sts_pkg::CHAN_W-1:0] channel_q;
	logic last_q;
	logic buf_end_q;
	logic load;
	logic fin;

	assign load = head_valid && (!valid_q || smp.ready);
	assign fin = chan_q == head.cnt_m1;
	assign pop = load && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				chan_q <= fin ? '0 : chan_q + 1'b1;
			end else if (smp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_q <= head.sample;
			channel_q <= chan_q;
			last_q <= fin;
			buf_end_q <= fin && head.buf_end;
		end
	end

	assign smp.valid = valid_q;
	assign smp.sample = sample_q;
	assign smp.channel = channel_q;
	assign smp.last = last_q;
	assign smp.buffer_end = buf_end_q;

endmodule

@@ hdl/sine_tone_generator.sv @@
// sine tone generator, direct digital synthesis
// req: one word per audio frame; restart zeroes the phase before the frame,
//   end_of_buffer is copied to buffer_end on the frame's last copy
// smp: one word per channel copy of the frame, channel 0 first, last set on
//   the final copy; all copies of a frame carry the same sample
// cfg: register writes (0 phase step, 1 sample width, 2 channel count),
//   always ready; the user writes only while the block is idle, which the block does not enforce
// a frame goes through front stages s1-s3, the queue, then the smp output register
// throughput: one output word per cycle while smp is ready, so a frame gives
//   channel_count copies (clamped to 1 to 8) on the single output port
// a front pipeline (phase, quarter-wave table, scale) feeds an 8-frame queue;
//   req stays ready while queue credit remains, also while smp is stalled
// smp stall: the output register holds its word; the queue fills, then req
//   drops ready until copies drain
// reset: phase 0, step 440 hz at 44.1 khz, 16-bit samples, two channels,
//   queue empty
module sine_tone_generator #(
	parameter int PHASE_BITS = 32,
	parameter int QUARTER_TABLE_BITS = 8,
	parameter int MAX_CHANNELS = 8
) (
	input logic clk,
	input logic arst_n,
	sts_req_if.sink req,
	sts_smp_if.source smp,
	sts_cfg_if.sink cfg
);

	logic [31:0] phase_step_q;
	logic sample_width_q;
	logic [3:0] channel_count_q;
	logic [sts_pkg::CHAN_W-1:0] cnt_m1;

	logic push;
	logic pop;
	logic empty;
	sts_pkg::frame_t push_data;
	sts_pkg::frame_t head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= sts_pkg::RST_PHASE_STEP;
			sample_width_q <= sts_pkg::RST_SAMPLE_WIDTH;
			channel_count_q <= sts_pkg::RST_CHANNEL_COUNT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sts_pkg::REG_PHASE_STEP: phase_step_q <= cfg.data;
				sts_pkg::REG_SAMPLE_WIDTH: sample_width_q <= cfg.data[0];
				sts_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (channel_count_q == 4'd0) begin
			cnt_m1 = '0;
		end else if (channel_count_q > 4'(MAX_CHANNELS)) begin
			cnt_m1 = sts_pkg::CHAN_W'(MAX_CHANNELS - 1);
		end else begin
			cnt_m1 = sts_pkg::CHAN_W'(channel_count_q - 4'd1);
		end
	end

	sts_front #(
		.PHASE_BITS(PHASE_BITS),
		.QUARTER_TABLE_BITS(QUARTER_TABLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.phase_step(phase_step_q),
		.sample_width(sample_width_q),
		.cnt_m1(cnt_m1),
		.pop(pop),
		.push(push),
		.push_data(push_data)
	);

	sts_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(push_data),
		.pop(pop),
		.empty(empty),
		.rdata(head)
	);

	sts_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(!empty),
		.head(head),
		.pop(pop),
		.smp(smp)
	);

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid |-> smp.channel <= cnt_m1)
		else $error("channel index beyond channel count");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid && smp.last |-> smp.channel == cnt_m1)
		else $error("last copy not on final channel");

	a_chan_seq: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid && smp.ready && !smp.last |=>
		smp.valid && smp.channel == 3'($past(smp.channel) + 3'd1))
		else $error("channel copies not contiguous");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid && !sample_width_q |->
		smp.sample <= 16'sd127 && smp.sample >= -16'sd127)
		else $error("8-bit sample out of range");

endmodule
